### sv/lswm_pkg.sv
// Package with shared types and constants of the LED strip wipe mask.
`timescale 1ns / 1ps
package lswm_pkg;

	localparam int unsigned MAX_LEDS  = 1024;
	localparam int unsigned DIV_STEPS = 11;
	localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

	localparam logic [1:0] REQ_TIME    = 2'd0;
	localparam logic [1:0] REQ_PIXEL   = 2'd1;
	localparam logic [1:0] REQ_RESTART = 2'd2;

	localparam logic [1:0] STYLE_FROM_START  = 2'd0;
	localparam logic [1:0] STYLE_FROM_END    = 2'd1;
	localparam logic [1:0] STYLE_FROM_CENTRE = 2'd2;
	localparam logic [1:0] STYLE_TO_CENTRE   = 2'd3;

	localparam logic [1:0] CFG_WIPE_STYLE  = 2'd0;
	localparam logic [1:0] CFG_WIPE_OUT    = 2'd1;
	localparam logic [1:0] CFG_DURATION_MS = 2'd2;
	localparam logic [1:0] CFG_LED_COUNT   = 2'd3;

	localparam logic [15:0] DURATION_RESET  = 16'd1000;
	localparam logic [10:0] LED_COUNT_RESET = 11'd1024;

	typedef struct packed {
		logic take;
		logic cfg_we;
		logic clamp;
		logic mul;
		logic div;
		logic win;
	} cmd_t;

endpackage

### sv/lswm_ctrl.sv
// Controller state machine: handshakes and sequencing of the bound recompute.
`timescale 1ns / 1ps
module lswm_ctrl
	import lswm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] req_type,
	output logic       out_valid,
	input  logic       out_stall,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	output cmd_t       cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CLAMP,
		S_MUL,
		S_DIV,
		S_WIN
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             idle;
	logic             start;

	assign idle      = (state_q == S_IDLE);
	assign cfg_ready = idle;
	assign in_stall  = !idle || cfg_valid || (out_valid_q && out_stall);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.take   = in_valid && !in_stall;
		cmd.cfg_we = cfg_valid && idle;
		cmd.clamp  = (state_q == S_CLAMP);
		cmd.mul    = (state_q == S_MUL);
		cmd.div    = (state_q == S_DIV);
		cmd.win    = (state_q == S_WIN);
	end

	assign start = cmd.cfg_we ||
		(cmd.take && (req_type == REQ_TIME || req_type == REQ_RESTART));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.take) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_CLAMP;
					end
				end
				S_CLAMP: begin
					state_q <= S_MUL;
				end
				S_MUL: begin
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
						state_q <= S_WIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_WIN: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### sv/lswm_dpath.sv
// Datapath: registers, elapsed time, multiply, serial divide, window bounds and pixel mask.
`timescale 1ns / 1ps
module lswm_dpath
	import lswm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	input  logic [1:0]  req_type,
	input  logic [15:0] delta_ms,
	input  logic [9:0]  pixel_index,
	input  logic [31:0] color_in,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output logic [31:0] color_out,
	output logic        done_res
);

	logic [1:0]  wipe_style_q;
	logic        wipe_out_q;
	logic [15:0] duration_q;
	logic [10:0] led_count_q;
	logic [15:0] elapsed_q;
	logic [10:0] lo_q;
	logic [10:0] hi_q;
	logic [15:0] fact_q;
	logic [15:0] rem_q;
	logic [10:0] num_q;
	logic [10:0] quo_q;

	logic [10:0] strip;
	logic [16:0] sum;
	logic [15:0] e_sat;
	logic [15:0] e_clamp;
	logic [26:0] prod;
	logic [16:0] rem_sh;
	logic        rem_ge;
	logic [10:0] v_raw;
	logic [10:0] v;
	logic [10:0] half;
	logic [10:0] hv;
	logic [10:0] h;
	logic [10:0] hh;
	logic [11:0] hi_c;
	logic [10:0] lo_n;
	logic [10:0] hi_n;
	logic        in_win;
	logic        hidden;

	assign strip = (32'(led_count_q) > MAX_LEDS) ? 11'(MAX_LEDS) : led_count_q;

	assign sum     = {1'b0, elapsed_q} + {1'b0, delta_ms};
	assign e_sat   = (sum > {1'b0, duration_q}) ? duration_q : sum[15:0];
	assign e_clamp = (elapsed_q > duration_q) ? duration_q : elapsed_q;
	assign prod    = 27'(strip) * 27'(fact_q);

	assign rem_sh = {rem_q, num_q[10]};
	assign rem_ge = (rem_sh >= {1'b0, duration_q});

	always_comb begin
		v_raw = quo_q;
		if (duration_q == 16'd0) begin
			v_raw = wipe_out_q ? 11'd0 : strip;
		end
		v    = (v_raw > strip) ? strip : v_raw;
		half = strip >> 1;
		hv   = v >> 1;
		h    = strip - v;
		hh   = h >> 1;
		hi_c = {1'b0, half} + {1'b0, hv};
		lo_n = 11'd0;
		hi_n = strip;
		case (wipe_style_q)
			STYLE_FROM_START: begin
				lo_n = v;
				hi_n = strip;
			end
			STYLE_FROM_END: begin
				lo_n = 11'd0;
				hi_n = strip - v;
			end
			STYLE_FROM_CENTRE: begin
				lo_n = (half > hv) ? (half - hv) : 11'd0;
				hi_c = {1'b0, half} + {1'b0, hv};
				hi_n = (hi_c > {1'b0, strip}) ? strip : hi_c[10:0];
			end
			STYLE_TO_CENTRE: begin
				lo_n = (half > hh) ? (half - hh) : 11'd0;
				hi_c = {1'b0, half} + {1'b0, hh} + {11'd0, h[0]};
				hi_n = (hi_c > {1'b0, strip}) ? strip : hi_c[10:0];
			end
			default: begin
				lo_n = v;
				hi_n = strip;
			end
		endcase
	end

	assign in_win = ({1'b0, pixel_index} >= lo_q) && ({1'b0, pixel_index} < hi_q);
	always_comb begin
		hidden = 1'b0;
		if ({1'b0, pixel_index} < strip) begin
			hidden = (wipe_style_q == STYLE_FROM_CENTRE) ? !in_win : in_win;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wipe_style_q <= STYLE_FROM_START;
			wipe_out_q   <= 1'b0;
			duration_q   <= DURATION_RESET;
			led_count_q  <= LED_COUNT_RESET;
			elapsed_q    <= '0;
			lo_q         <= '0;
			hi_q         <= '0;
		end else begin
			if (cmd.cfg_we) begin
				case (cfg_index)
					CFG_WIPE_STYLE:  wipe_style_q <= cfg_data[1:0];
					CFG_WIPE_OUT:    wipe_out_q   <= cfg_data[0];
					CFG_DURATION_MS: duration_q   <= cfg_data;
					CFG_LED_COUNT:   led_count_q  <= cfg_data[10:0];
					default:         wipe_style_q <= wipe_style_q;
				endcase
			end
			if (cmd.take) begin
				if (req_type == REQ_TIME) begin
					elapsed_q <= e_sat;
				end else if (req_type == REQ_RESTART) begin
					elapsed_q <= '0;
				end
			end
			if (cmd.clamp) begin
				elapsed_q <= e_clamp;
			end
			if (cmd.win) begin
				lo_q      <= lo_n;
				hi_q      <= hi_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			color_out <= '0;
			case (req_type)
				REQ_TIME: begin
					done_res <= (e_sat >= duration_q);
				end
				REQ_PIXEL: begin
					color_out <= hidden ? 32'd0 : color_in;
					done_res  <= (elapsed_q >= duration_q);
				end
				REQ_RESTART: begin
					done_res <= (duration_q == 16'd0);
				end
				default: begin
					done_res <= (elapsed_q >= duration_q);
				end
			endcase
		end
		if (cmd.clamp) begin
			fact_q <= wipe_out_q ? (duration_q - e_clamp) : e_clamp;
		end
		if (cmd.mul) begin
			rem_q <= prod[26:11];
			num_q <= prod[10:0];
		end
		if (cmd.div) begin
			rem_q <= rem_ge ? 16'(rem_sh - {1'b0, duration_q}) : rem_sh[15:0];
			num_q <= {num_q[9:0], 1'b0};
			quo_q <= {quo_q[9:0], rem_ge};
		end
	end

endmodule

### sv/led_strip_wipe_mask.sv
// Top level of the LED strip wipe mask: controller and datapath.
//
// Input words arrive on in_valid/in_stall with req_type, delta_ms, pixel_index
// and color_in; each accepted word yields exactly one result word on
// out_valid/out_stall carrying color_out and done_res.
// Pixel results are registered and appear in the cycle after acceptance; pixel
// words stream one per cycle while the input is not stalled. A time or restart
// word also delivers its result in the cycle after acceptance, then the visible
// count and window bounds are recomputed by a clamp step, an 11x16 multiply, a
// one-bit-per-cycle restoring divider and a window step, and the input stalls
// until the recompute is done. A write on the cfg_valid/cfg_ready channel starts
// the same recompute; cfg_ready is low and the input stalls while it runs.
// While the receiver stalls a pending result, that result holds and the input
// stalls in turn, so no word is lost.
// Reset clears the elapsed time and bounds, sets duration to 1000 ms and the
// LED count to 1024, and leaves no result pending.
`timescale 1ns / 1ps
module led_strip_wipe_mask
	import lswm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [15:0] delta_ms,
	input  logic [9:0]  pixel_index,
	input  logic [31:0] color_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] color_out,
	output logic        done_res,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	cmd_t cmd;

	lswm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.req_type  (req_type),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cmd       (cmd)
	);

	lswm_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.req_type    (req_type),
		.delta_ms    (delta_ms),
		.pixel_index (pixel_index),
		.color_in    (color_in),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.color_out   (color_out),
		.done_res    (done_res)
	);

endmodule

### tb/sv/led_strip_wipe_mask_chk.sv
// Checker that predicts and compares the result words of the LED strip wipe mask.
`timescale 1ns / 1ps
module led_strip_wipe_mask_chk
	import lswm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [15:0] delta_ms,
	input  logic [9:0]  pixel_index,
	input  logic [31:0] color_in,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [31:0] color_out,
	input  logic        done_res,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          errors,
	output int          pending
);

	typedef struct packed {
		logic [31:0] color;
		logic        done;
	} mask_word_t;

	mask_word_t  mask_words[$];

	logic [1:0]  style;
	logic        wipe_out_q;
	logic [15:0] dur;
	logic [10:0] cnt;
	logic [15:0] elapsed;
	logic [10:0] win_lo;
	logic [10:0] win_hi;

	assign pending = mask_words.size();

	function automatic int unsigned strip_len();
		return (cnt > MAX_LEDS) ? MAX_LEDS : cnt;
	endfunction

	function automatic void refresh_window();
		int unsigned t, d, v, half, hv, h, hh, lo, hi;
		t = strip_len();
		d = dur;
		if (elapsed > d) elapsed = d[15:0];
		if (d == 0) begin
			v = wipe_out_q ? 0 : t;
		end else if (wipe_out_q) begin
			v = (t * (d - elapsed)) / d;
		end else begin
			v = (t * elapsed) / d;
		end
		if (v > t) v = t;
		half = t / 2;
		case (style)
			STYLE_FROM_START: begin
				lo = v;
				hi = t;
			end
			STYLE_FROM_END: begin
				lo = 0;
				hi = t - v;
			end
			STYLE_FROM_CENTRE: begin
				hv = v / 2;
				lo = (half > hv) ? half - hv : 0;
				hi = half + hv;
				if (hi > t) hi = t;
			end
			default: begin
				h = t - v;
				hh = h / 2;
				lo = (half > hh) ? half - hh : 0;
				hi = half + hh + (h & 1);
				if (hi > t) hi = t;
			end
		endcase
		win_lo = lo[10:0];
		win_hi = hi[10:0];
	endfunction

	function automatic mask_word_t predict_word(input logic [1:0] req, input logic [15:0] delta,
			input logic [9:0] idx, input logic [31:0] color);
		mask_word_t  w;
		int unsigned sum;
		logic        in_win;
		logic        hidden;
		w.color = '0;
		case (req)
			REQ_TIME: begin
				sum = elapsed + delta;
				elapsed = (sum > dur) ? dur : sum[15:0];
				refresh_window();
			end
			REQ_PIXEL: begin
				hidden = 1'b0;
				if (idx < strip_len()) begin
					in_win = (idx >= win_lo) && (idx < win_hi);
					hidden = (style == STYLE_FROM_CENTRE) ? !in_win : in_win;
				end
				w.color = hidden ? '0 : color;
			end
			REQ_RESTART: begin
				elapsed = '0;
				refresh_window();
			end
			default: ;
		endcase
		w.done = (elapsed >= dur);
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		mask_word_t want;
		if (!arst_n) begin
			style = STYLE_FROM_START;
			wipe_out_q = 1'b0;
			dur = DURATION_RESET;
			cnt = LED_COUNT_RESET;
			elapsed = '0;
			win_lo = '0;
			win_hi = '0;
			mask_words.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (mask_words.size() == 0) begin
					$display("%0t: result word with nothing pending, color_out %h done_res %b",
						$time, color_out, done_res);
					errors++;
				end else begin
					want = mask_words.pop_front();
					if (color_out !== want.color) begin
						$display("%0t: color_out expected %h actual %h",
							$time, want.color, color_out);
						errors++;
					end
					if (done_res !== want.done) begin
						$display("%0t: done_res expected %b actual %b",
							$time, want.done, done_res);
						errors++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_WIPE_STYLE:  style = cfg_data[1:0];
					CFG_WIPE_OUT:    wipe_out_q = cfg_data[0];
					CFG_DURATION_MS: dur = cfg_data;
					CFG_LED_COUNT:   cnt = cfg_data[10:0];
					default: ;
				endcase
				refresh_window();
			end
			if (in_valid && !in_stall)
				mask_words.push_back(predict_word(req_type, delta_ms, pixel_index, color_in));
		end
	end

endmodule

### tb/sv/led_strip_wipe_mask_tb.sv
// Top of the LED strip wipe mask testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module led_strip_wipe_mask_tb
	import lswm_pkg::*;
();

	localparam logic [1:0] REQ_UNKNOWN = 2'd3;
	localparam int HOLD_CYCLES = 90;
	localparam int PHASE_ITEMS = 54;
	localparam int PHASES      = 8;

	typedef struct {
		logic [1:0]  style;
		logic        wipe_out;
		logic [15:0] dur;
		logic [10:0] cnt;
	} phase_cfg_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  req_type = REQ_TIME;
	logic [15:0] delta_ms = '0;
	logic [9:0]  pixel_index = '0;
	logic [31:0] color_in = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] color_out;
	logic        done_res;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = CFG_WIPE_STYLE;
	logic [15:0] cfg_data = '0;

	int          errors;
	int          pending;
	int          sender_pct = 0;
	int          stall_pct = 0;
	logic        hold_req = 1'b0;
	logic        hold_seen = 1'b0;
	int          hold_left = 0;
	logic [15:0] cur_dur = DURATION_RESET;
	logic [10:0] cur_cnt = LED_COUNT_RESET;
	phase_cfg_t  plan [PHASES];

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	led_strip_wipe_mask DUT (.*);

	led_strip_wipe_mask_chk mask_chk (.*);

	initial begin
		#5_000_000;
		$display("led_strip_wipe_mask: mismatch");
		$finish;
	end

	// The receiver stalls at random, or for a long stretch when asked.
	initial begin
		forever begin
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(0, 99) < stall_pct);
			end
			@(posedge clk);
		end
	end

	task automatic send_word(input logic [1:0] req, input logic [15:0] delta,
			input logic [9:0] idx, input logic [31:0] color);
		while ($urandom_range(0, 99) < sender_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= req;
		delta_ms <= delta;
		pixel_index <= idx;
		color_in <= color;
		do @(posedge clk); while (!(in_valid && !in_stall));
	endtask

	task automatic send_random();
		int unsigned pick;
		int unsigned lim;
		logic [1:0]  req;
		logic [15:0] delta;
		logic [9:0]  idx;
		pick = $urandom_range(0, 99);
		req = (pick < 68) ? REQ_PIXEL : (pick < 88) ? REQ_TIME :
			(pick < 95) ? REQ_RESTART : REQ_UNKNOWN;
		delta = ($urandom_range(0, 4) == 0) ? 16'($urandom) :
			16'($urandom_range(0, cur_dur / 16 + 1));
		lim = (cur_cnt == 0) ? 2 : (cur_cnt > 1023) ? 1023 : cur_cnt;
		idx = ($urandom_range(0, 4) == 0) ? 10'($urandom) : 10'($urandom_range(0, lim));
		send_word(req, delta, idx, $urandom);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Waits for every pending word and for the recompute that follows it.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	initial begin
		plan = '{
			'{STYLE_FROM_END,    1'b0, 16'd200,   11'd1024},
			'{STYLE_FROM_CENTRE, 1'b1, 16'd1,     11'd2047},
			'{STYLE_TO_CENTRE,   1'b0, 16'd65535, 11'd37},
			'{STYLE_TO_CENTRE,   1'b1, 16'd0,     11'd1},
			'{STYLE_FROM_CENTRE, 1'b0, 16'd300,   11'd0},
			'{STYLE_FROM_START,  1'b1, 16'd150,   11'd1023},
			'{STYLE_FROM_END,    1'b1, 16'd5000,  11'd1500},
			'{STYLE_TO_CENTRE,   1'b0, 16'd97,    11'd513}
		};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(REQ_PIXEL, 16'h0000, 10'd0, 32'hFFFF_FFFF);
		send_word(REQ_PIXEL, 16'hFFFF, 10'h3FF, 32'h0000_0000);
		send_word(REQ_UNKNOWN, 16'hFFFF, 10'h3FF, 32'hFFFF_FFFF);
		send_word(REQ_TIME, 16'd0, 10'd0, 32'h0);
		send_word(REQ_PIXEL, 16'd0, 10'd0, 32'hFFFF_FFFF);
		send_word(REQ_TIME, 16'd250, 10'd0, 32'h0);
		send_word(REQ_PIXEL, 16'd0, 10'd255, 32'h1234_5678);
		send_word(REQ_PIXEL, 16'd0, 10'd256, 32'h8765_4321);
		send_word(REQ_PIXEL, 16'd0, 10'h3FF, 32'hFFFF_FFFF);
		send_word(REQ_RESTART, 16'd0, 10'd0, 32'h0);
		send_word(REQ_PIXEL, 16'd0, 10'd0, 32'hFFFF_FFFF);
		send_word(REQ_TIME, 16'hFFFF, 10'd0, 32'h0);
		send_word(REQ_PIXEL, 16'd0, 10'h3FF, 32'hFFFF_FFFF);
		send_word(REQ_TIME, 16'd1, 10'd0, 32'h0);
		send_word(REQ_UNKNOWN, 16'd0, 10'd0, 32'h0);
		send_word(REQ_RESTART, 16'd0, 10'd0, 32'h0);
		send_word(REQ_TIME, 16'd999, 10'd0, 32'h0);
		send_word(REQ_PIXEL, 16'd0, 10'd998, 32'hA5A5_5A5A);
		send_word(REQ_PIXEL, 16'd0, 10'd999, 32'h5A5A_A5A5);
		send_word(REQ_TIME, 16'd1, 10'd0, 32'h0);
		send_word(REQ_PIXEL, 16'd0, 10'd999, 32'hFFFF_FFFF);
		drain();

		for (int p = 0; p < PHASES; p++) begin
			write_reg(CFG_WIPE_STYLE, {14'd0, plan[p].style});
			write_reg(CFG_WIPE_OUT, {15'd0, plan[p].wipe_out});
			write_reg(CFG_DURATION_MS, plan[p].dur);
			write_reg(CFG_LED_COUNT, {5'd0, plan[p].cnt});
			cur_dur = plan[p].dur;
			cur_cnt = plan[p].cnt;
			sender_pct = (p % 4 == 1) ? 57 : (p % 4 == 3) ? 13 : 0;
			stall_pct = (p % 4 == 2) ? 57 : (p % 4 == 3) ? 13 : 0;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if ((p == 0 || p == 4) && i == 8)
					hold_req <= ~hold_req;
				send_random();
			end
			drain();
		end

		if (errors == 0 && pending == 0) begin
			$display("led_strip_wipe_mask: match");
		end else begin
			$display("led_strip_wipe_mask: mismatch");
		end
		$finish;
	end

endmodule
